// ----- design/ready_sleep_queue_core_dispatcher_assert.svh -----
// Assertion macros for the ready/sleep queue core dispatcher.
// Used by the top level; depends on clk_i and rst_ni being in scope.
`ifndef READY_SLEEP_QUEUE_CORE_DISPATCHER_ASSERT_SVH
`define READY_SLEEP_QUEUE_CORE_DISPATCHER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RSSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Condition that must hold on every clock edge outside reset.
`define RSSQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`endif

// ----- design/rssq_pkg.sv -----
// Shared types and constants for the ready/sleep queue core dispatcher.
// No dependencies; imported by the front, back and top modules.
package rssq_pkg;

  localparam int unsigned NUM_CORES_DEF   = 8;
  localparam int unsigned READY_DEPTH_DEF = 32;
  localparam int unsigned SLEEP_DEPTH_DEF = 16;
  localparam int unsigned MAX_CORES       = 8;

  localparam int unsigned PID_W   = 16;
  localparam int unsigned SLEEP_W = 16;
  localparam int unsigned FREE_W  = 8;
  localparam int unsigned CORE_W  = 3;
  localparam int unsigned QUANT_W = 16;
  localparam int unsigned LIM_W   = 4;
  localparam int unsigned CYC_W   = 32;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 40;
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned CFG_DW  = 16;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ADD     = 2'd1,
    OP_REQUEUE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_POLICY   = 2'd0,
    REG_QUANTUM  = 2'd1,
    REG_CORES    = 2'd2,
    REG_RESERVED = 2'd3
  } reg_e;

  typedef enum logic {
    KIND_ASSIGN = 1'b0,
    KIND_DROP   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [FREE_W-1:0]  core_free;
    logic [SLEEP_W-1:0] sleep_ticks;
    logic [PID_W-1:0]   pid;
    op_e                op;
  } item_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } qctl_t;

endpackage

// ----- design/ready_sleep_queue_core_dispatcher.sv -----
// Top level of the ready/sleep queue core dispatcher.
// Depends on rssq_pkg, rssq_front, rssq_back and the assertion macro header.
//
// Usage:
// Input items arrive as beats on the s_axis channel: a tick (op 0) carrying
// a free-core mask, an add (op 1) or a requeue (op 2) carrying a process id
// and a sleep count. Results leave as beats on the m_axis channel: tuser is
// the kind (0 assignment, 1 drop), tlast marks the final result of an item.
// Configuration registers (policy, quantum, cores in use) are written through
// cfg_we_i/cfg_addr_i/cfg_wdata_i while the block is idle.
// Flow: a two-beat input queue decouples acceptance from execution. An add
// or requeue is executed by the back end as it leaves the queue; a drop is
// emitted from a separate drop state. On a tick the back end walks the sleep
// list one entry per cycle, then the cores in order, with a registered read
// of the ready FIFO memory for each assignment, waiting whenever the result
// register is stalled.
// Reset clears the counters, pointers and the queue; memory contents are
// left as they are and are never read before being written.
// When the receiver stalls, the result register holds and the sequencer
// waits; the input queue keeps taking beats until it holds two.
module ready_sleep_queue_core_dispatcher #(
  parameter int unsigned NUM_CORES   = rssq_pkg::NUM_CORES_DEF,
  parameter int unsigned READY_DEPTH = rssq_pkg::READY_DEPTH_DEF,
  parameter int unsigned SLEEP_DEPTH = rssq_pkg::SLEEP_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rssq_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [rssq_pkg::CFG_DW-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // op[1:0], pid[17:2], sleep_ticks[33:18], core_free[41:34], zeros above
  input  logic [rssq_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // core[2:0], pid_res[18:3], no_limit[19], slice[35:20], zeros above
  output logic [rssq_pkg::OUT_W-1:0]    m_axis_tdata,
  // kind
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);
  import rssq_pkg::*;
  `include "ready_sleep_queue_core_dispatcher_assert.svh"

  localparam int unsigned RCW = $clog2(READY_DEPTH + 1);

  item_t              in_item, head_item;
  qctl_t              qctl;
  logic               head_valid;
  logic [CORE_W-1:0]  core;
  logic [PID_W-1:0]   pid_res;
  logic               no_limit;
  logic [QUANT_W-1:0] slice_v;
  logic [RCW-1:0]     ready_count;

  // The packed struct puts op in the lowest bits, matching the tdata layout.
  assign in_item = item_t'(s_axis_tdata[$bits(item_t)-1:0]);

  rssq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .head_item_o  (head_item),
    .ctl_i        (qctl),
    .head_valid_o (head_valid)
  );

  rssq_back #(
    .NUM_CORES   (NUM_CORES),
    .READY_DEPTH (READY_DEPTH),
    .SLEEP_DEPTH (SLEEP_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .head_valid_i   (head_valid),
    .head_item_i    (head_item),
    .ctl_o          (qctl),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_kind_o     (m_axis_tuser),
    .out_core_o     (core),
    .out_pid_o      (pid_res),
    .out_no_limit_o (no_limit),
    .out_slice_o    (slice_v),
    .out_last_o     (m_axis_tlast),
    .ready_count_o  (ready_count)
  );

  assign m_axis_tdata = {4'b0, slice_v, no_limit, pid_res, core};

  // A drop is always the only result of its item.
  `RSSQ_ASSERT_IMP(a_drop_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "drop not last")
  // An assignment under either policy carries exactly one of no_limit or a slice.
  `RSSQ_ASSERT_IMP(a_assign_grant, m_axis_tvalid && !m_axis_tuser,
                   no_limit == (slice_v == '0), "assignment grant inconsistent")
  // The ready FIFO never counts past its depth.
  `RSSQ_ASSERT_ALWAYS(a_ready_bound, ready_count <= RCW'(READY_DEPTH), "ready overflow")

endmodule

// ----- design/rssq_front.sv -----
// Front end: accepts input beats and holds them in a short item queue.
// Depends on rssq_pkg for the item type.
module rssq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rssq_pkg::item_t     in_item_i,
  output rssq_pkg::item_t     head_item_o,
  input  rssq_pkg::qctl_t     ctl_i,
  output logic                head_valid_o
);
  import rssq_pkg::*;

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_item_o  = slot_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = ctl_i.pop && ctl_i.valid;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// ----- design/rssq_back.sv -----
// Back end: ready FIFO, sleep list, cycle counter, dispatch sequencer, result register.
// Depends on rssq_pkg; fed by rssq_front through the item queue.
module rssq_back #(
  parameter int unsigned NUM_CORES   = rssq_pkg::NUM_CORES_DEF,
  parameter int unsigned READY_DEPTH = rssq_pkg::READY_DEPTH_DEF,
  parameter int unsigned SLEEP_DEPTH = rssq_pkg::SLEEP_DEPTH_DEF,
  localparam int unsigned RIW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1,
  localparam int unsigned RCW = $clog2(READY_DEPTH + 1),
  localparam int unsigned SIW = (SLEEP_DEPTH > 1) ? $clog2(SLEEP_DEPTH) : 1,
  localparam int unsigned SCW = $clog2(SLEEP_DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rssq_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [rssq_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                           head_valid_i,
  input  rssq_pkg::item_t                head_item_i,
  output rssq_pkg::qctl_t                ctl_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_kind_o,
  output logic [rssq_pkg::CORE_W-1:0]    out_core_o,
  output logic [rssq_pkg::PID_W-1:0]     out_pid_o,
  output logic                           out_no_limit_o,
  output logic [rssq_pkg::QUANT_W-1:0]   out_slice_o,
  output logic                           out_last_o,
  output logic [RCW-1:0]                 ready_count_o
);
  import rssq_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_DROP, ST_SWEEP, ST_DISP, ST_DRD} state_e;

  localparam logic [LIM_W-1:0] CoreCap =
    LIM_W'((NUM_CORES < MAX_CORES) ? NUM_CORES : MAX_CORES);

  // configuration
  logic               policy_q;
  logic [QUANT_W-1:0] quantum_q;
  logic [LIM_W-1:0]   cores_q;

  // control state
  state_e             state_q, state_d;
  logic [CYC_W-1:0]   cycle_q, cycle_d, now_q, now_d;
  logic [RIW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [RCW-1:0]     rcnt_q, rcnt_d;
  logic [SCW-1:0]     scnt_q, scnt_d, idx_q, idx_d, kept_q, kept_d;
  logic [LIM_W-1:0]   c_q, c_d;
  logic [FREE_W-1:0]  free_q, free_d;
  logic [PID_W-1:0]   drop_pid_q, drop_pid_d;

  // result register
  logic               ov_q, ov_d, ok_q, ok_d, onl_q, onl_d, olast_q, olast_d;
  logic [CORE_W-1:0]  oc_q, oc_d;
  logic [PID_W-1:0]   op_q, op_d;
  logic [QUANT_W-1:0] os_q, os_d;

  // memories
  logic [PID_W-1:0]   rmem [READY_DEPTH];
  logic [PID_W-1:0]   rdata_q;
  logic               rmem_we, rmem_re;
  logic [RIW-1:0]     rmem_waddr;
  logic [PID_W-1:0]   rmem_wdata;
  logic [CYC_W-1:0]   wake_mem [SLEEP_DEPTH];
  logic [PID_W-1:0]   sid_mem [SLEEP_DEPTH];
  logic               smem_we;
  logic [SIW-1:0]     smem_waddr;
  logic [CYC_W-1:0]   smem_wake;
  logic [PID_W-1:0]   smem_id;

  logic               can_emit, ready_full, due, lim_hit;
  logic [LIM_W-1:0]   limit;
  logic [CYC_W-1:0]   cur_wake, age;
  logic [PID_W-1:0]   cur_id;
  logic [MAX_CORES-1:0] upper_mask;

  function automatic logic [RIW-1:0] ptr_inc(input logic [RIW-1:0] p);
    ptr_inc = (p == RIW'(READY_DEPTH - 1)) ? '0 : p + RIW'(1);
  endfunction

  assign can_emit   = !ov_q || out_ready_i;
  assign ready_full = (rcnt_q == RCW'(READY_DEPTH));
  assign limit      = (cores_q < CoreCap) ? cores_q : CoreCap;
  assign cur_wake   = wake_mem[idx_q[SIW-1:0]];
  assign cur_id     = sid_mem[idx_q[SIW-1:0]];
  assign age        = now_q - cur_wake;
  assign due        = !age[CYC_W-1];
  assign lim_hit    = (c_q >= limit);

  // Cores above the one being served and below the limit.
  always_comb begin
    for (int k = 0; k < MAX_CORES; k++) begin
      upper_mask[k] = (LIM_W'(k) > c_q) && (LIM_W'(k) < limit);
    end
  end

  assign ctl_o.valid = head_valid_i;
  assign ctl_o.pop   = (state_q == ST_IDLE) && head_valid_i;

  always_comb begin
    state_d = state_q;  cycle_d = cycle_q;  now_d = now_q;
    head_d = head_q;    tail_d = tail_q;    rcnt_d = rcnt_q;
    scnt_d = scnt_q;    idx_d = idx_q;      kept_d = kept_q;
    c_d = c_q;          free_d = free_q;    drop_pid_d = drop_pid_q;
    ov_d = ov_q && !out_ready_i;
    ok_d = ok_q; onl_d = onl_q; olast_d = olast_q; oc_d = oc_q; op_d = op_q; os_d = os_q;
    rmem_we = 1'b0; rmem_waddr = tail_q; rmem_wdata = head_item_i.pid; rmem_re = 1'b0;
    smem_we = 1'b0; smem_waddr = scnt_q[SIW-1:0];
    smem_wake = cycle_q + CYC_W'(head_item_i.sleep_ticks); smem_id = head_item_i.pid;

    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          drop_pid_d = head_item_i.pid;
          unique case (head_item_i.op)
            OP_ADD, OP_REQUEUE: begin
              if (head_item_i.op == OP_REQUEUE && head_item_i.sleep_ticks != '0) begin
                if (scnt_q == SCW'(SLEEP_DEPTH)) begin
                  state_d = ST_DROP;
                end else begin
                  smem_we = 1'b1;
                  scnt_d  = scnt_q + SCW'(1);
                end
              end else if (ready_full) begin
                state_d = ST_DROP;
              end else begin
                rmem_we = 1'b1;
                tail_d  = ptr_inc(tail_q);
                rcnt_d  = rcnt_q + RCW'(1);
              end
            end
            OP_TICK: begin
              now_d   = cycle_q;
              cycle_d = cycle_q + CYC_W'(1);
              free_d  = head_item_i.core_free;
              idx_d   = '0;
              kept_d  = '0;
              state_d = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      ST_DROP: begin
        if (can_emit) begin
          ov_d = 1'b1; ok_d = KIND_DROP; oc_d = '0; op_d = drop_pid_q;
          onl_d = 1'b0; os_d = '0; olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        // One sleeper per cycle; those not woken are compacted toward the front.
        if (idx_q == scnt_q) begin
          scnt_d  = kept_q;
          c_d     = '0;
          state_d = ST_DISP;
        end else begin
          if (due && !ready_full) begin
            rmem_we    = 1'b1;
            rmem_wdata = cur_id;
            tail_d     = ptr_inc(tail_q);
            rcnt_d     = rcnt_q + RCW'(1);
          end else begin
            smem_we    = 1'b1;
            smem_waddr = kept_q[SIW-1:0];
            smem_wake  = cur_wake;
            smem_id    = cur_id;
            kept_d     = kept_q + SCW'(1);
          end
          idx_d = idx_q + SCW'(1);
        end
      end
      ST_DISP: begin
        if (lim_hit) begin
          state_d = ST_IDLE;
        end else if (free_q[c_q[CORE_W-1:0]] && rcnt_q != '0) begin
          rmem_re = 1'b1;
          head_d  = ptr_inc(head_q);
          rcnt_d  = rcnt_q - RCW'(1);
          state_d = ST_DRD;
        end else begin
          c_d = c_q + LIM_W'(1);
        end
      end
      ST_DRD: begin
        if (can_emit) begin
          ov_d = 1'b1; ok_d = KIND_ASSIGN; oc_d = c_q[CORE_W-1:0]; op_d = rdata_q;
          onl_d = !policy_q;
          os_d  = !policy_q ? '0 : ((quantum_q == '0) ? QUANT_W'(1) : quantum_q);
          olast_d = !((rcnt_q != '0) && ((free_q & upper_mask) != '0));
          c_d     = c_q + LIM_W'(1);
          state_d = ST_DISP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cycle_q <= '0; head_q <= '0; tail_q <= '0;
      rcnt_q <= '0; scnt_q <= '0; ov_q <= 1'b0;
      now_q <= '0; idx_q <= '0; kept_q <= '0; c_q <= '0; free_q <= '0;
      drop_pid_q <= '0;
      ok_q <= 1'b0; onl_q <= 1'b0; olast_q <= 1'b0; oc_q <= '0; op_q <= '0; os_q <= '0;
      policy_q <= 1'b0; quantum_q <= QUANT_W'(5); cores_q <= LIM_W'(4);
    end else begin
      state_q <= state_d; cycle_q <= cycle_d; head_q <= head_d; tail_q <= tail_d;
      rcnt_q <= rcnt_d; scnt_q <= scnt_d; ov_q <= ov_d;
      now_q <= now_d; idx_q <= idx_d; kept_q <= kept_d; c_q <= c_d; free_q <= free_d;
      drop_pid_q <= drop_pid_d;
      ok_q <= ok_d; onl_q <= onl_d; olast_q <= olast_d; oc_q <= oc_d; op_q <= op_d;
      os_q <= os_d;
      if (cfg_we_i) begin
        case (reg_e'(cfg_addr_i))
          REG_POLICY:  policy_q  <= cfg_wdata_i[0];
          REG_QUANTUM: quantum_q <= cfg_wdata_i[QUANT_W-1:0];
          REG_CORES:   cores_q   <= cfg_wdata_i[LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rmem_we) begin
      rmem[rmem_waddr] <= rmem_wdata;
    end
    if (rmem_re) begin
      rdata_q <= rmem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (smem_we) begin
      wake_mem[smem_waddr] <= smem_wake;
      sid_mem[smem_waddr]  <= smem_id;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_kind_o     = ok_q;
  assign out_core_o     = oc_q;
  assign out_pid_o      = op_q;
  assign out_no_limit_o = onl_q;
  assign out_slice_o    = os_q;
  assign out_last_o     = olast_q;
  assign ready_count_o  = rcnt_q;

endmodule
